FILE: rtl/core/vurt_pkg.sv
package vurt_pkg;

    localparam int NameMemDepthDef = 4096;
    localparam int DotsPerLineDef  = 341;
    localparam logic [8:0] LinePre  = 9'h1ff;
    localparam logic [8:0] LineWrap = 9'd261;
    localparam logic [8:0] LineVis  = 9'd240;
    localparam logic [8:0] LineVbl  = 9'd241;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_CTRL   = 3'd0,
        REG_MASK   = 3'd1,
        REG_STATUS = 3'd2,
        REG_OAMADR = 3'd3,
        REG_OAMDAT = 3'd4,
        REG_SCROLL = 3'd5,
        REG_ADDR   = 3'd6,
        REG_DATA   = 3'd7
    } reg_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_NAME = 2'd1,
        SRC_PAL  = 2'd2
    } src_t;

    function automatic logic [11:0] name_index(input logic [2:0] mir, input logic [13:0] a);
        logic [1:0] q;
        logic [1:0] b;
        begin
            q = a[11:10];
            case (mir)
                3'd1: b = {1'b0, q[0]};
                3'd2: b = 2'd0;
                3'd3: b = 2'd1;
                3'd4: b = q;
                default: b = {1'b0, q[1]};
            endcase
            name_index = {b, a[9:0]};
        end
    endfunction

    function automatic logic [4:0] pal_index(input logic [13:0] a);
        begin
            pal_index = (a[1:0] == 2'd0) ? {1'b0, a[3:0]} : a[4:0];
        end
    endfunction

endpackage

FILE: rtl/core/video_unit_register_and_timing_core.sv
// picture unit cpu side: dot/line timing plus register file
// in channel: in_valid/in_stall with operation, reg_index, write_data;
// every request gives exactly one result on the out channel
// (out_valid/out_stall). a request is taken at an edge with valid high and
// stall low. the result shows up on the cycle after acceptance; throughput
// is one request per cycle unless a held result stalls the in channel
// memories: sprite (256), name (NAME_MEM_DEPTH), palette (32) entries,
// each a synchronous ram read or written at the accept edge
// buffered data reads land in the read buffer when the next request is accepted;
// until then ld_reg marks a pending load so back-to-back data reads see it
// a stalled result is held in the output register while in_stall is high
// whenever the output register is full and stalled
// reset clears all control registers, sets vblank and puts the line
// counter on the pre-render line; memory contents stay undefined
// nametable_mirroring sits at apb address 0
module video_unit_register_and_timing_core
    import vurt_pkg::*;
#(
    parameter int NAME_MEM_DEPTH = NameMemDepthDef,
    parameter int DOTS_PER_LINE  = DotsPerLineDef
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        nmi_raise,
    output logic        frame_done,
    output logic        line_start,
    output logic [7:0]  line_number,
    output logic [7:0]  ctrl_value,
    output logic [7:0]  mask_value,
    output logic [7:0]  scroll_x,
    output logic [7:0]  scroll_y
);
    localparam int NAW = $clog2(NAME_MEM_DEPTH);

    logic [2:0]  mir_reg;
    logic [7:0]  ctrl_reg, mask_reg, oam_ptr_reg, sx_reg, sy_reg, rbuf_reg;
    logic        vbl_reg, tog_reg;
    logic [15:0] vptr_reg;
    logic [8:0]  dot_reg, line_reg;

    logic [7:0] spr_mem [256];
    logic [7:0] name_mem [NAME_MEM_DEPTH];
    logic [7:0] pal_mem [32];
    logic [7:0] spr_q, name_q, pal_q;

    // pending buffered load: the memory word sits in the registered ram output
    logic       ld_reg;
    src_t       ld_src_reg;

    // output register fields
    logic       ov_reg;
    logic [7:0] rd_reg, lnum_reg;
    logic       nmi_reg, fd_reg, ls_reg;
    logic       rd_oam_reg, rd_buf_reg;

    logic       acc;
    logic [13:0] va;
    logic [7:0]  buf_now;

    assign pready   = 1'b1;
    assign prdata   = {29'd0, mir_reg};
    assign in_stall = ov_reg & out_stall;
    assign acc      = in_valid & ~in_stall;
    assign va       = vptr_reg[13:0];

    // current buffer value including a load still in flight
    always_comb
    begin
        case (ld_src_reg)
            SRC_NAME: buf_now = name_q;
            SRC_PAL:  buf_now = pal_q;
            default:  buf_now = 8'd0;
        endcase
        if (!ld_reg)
            buf_now = rbuf_reg;
    end

    assign out_valid   = ov_reg;
    assign read_data   = rd_oam_reg ? spr_q : (rd_buf_reg ? buf_now : rd_reg);
    assign nmi_raise   = nmi_reg;
    assign frame_done  = fd_reg;
    assign line_start  = ls_reg;
    assign line_number = lnum_reg;
    assign ctrl_value  = ctrl_reg;
    assign mask_value  = mask_reg;
    assign scroll_x    = sx_reg;
    assign scroll_y    = sy_reg;

    wire is_rd   = acc && operation == OP_READ;
    wire is_wr   = acc && operation == OP_WRITE;
    wire dat_acc = (is_rd || is_wr) && reg_index == REG_DATA;
    wire in_name = va >= 14'h2000 && va < 14'h3f00;
    wire in_pal  = va >= 14'h3f00;
    // mirrored index folds back into a smaller name memory
    wire [11:0] nfull = name_index(mir_reg, va);
    wire [11:0] nwrap = ({1'b0, nfull} >= 13'(NAME_MEM_DEPTH)) ?
                        nfull - 12'(NAME_MEM_DEPTH) : nfull;
    wire [NAW-1:0] nidx = nwrap[NAW-1:0];

    // memories: one read or write per request; sprite read data is only
    // consumed while its result sits unaccepted, so hold it then
    always_ff @(posedge clk)
    begin
        if (is_wr && reg_index == REG_OAMDAT)
            spr_mem[oam_ptr_reg] <= write_data;
        if (is_rd && reg_index == REG_OAMDAT)
            spr_q <= spr_mem[oam_ptr_reg];
        if (is_wr && reg_index == REG_DATA && in_name)
            name_mem[nidx] <= write_data;
        if (is_rd && reg_index == REG_DATA && in_name)
            name_q <= name_mem[nidx];
        if (is_wr && reg_index == REG_DATA && in_pal)
            pal_mem[pal_index(va)] <= write_data;
        if (is_rd && reg_index == REG_DATA && in_pal)
            pal_q <= pal_mem[pal_index(va)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mir_reg <= '0; ctrl_reg <= '0; mask_reg <= '0; oam_ptr_reg <= '0;
            sx_reg <= '0; sy_reg <= '0; rbuf_reg <= '0; vbl_reg <= 1'b1;
            tog_reg <= 1'b0; vptr_reg <= '0; dot_reg <= '0; line_reg <= LinePre;
            ld_reg <= 1'b0; ld_src_reg <= SRC_ZERO;
            ov_reg <= 1'b0; rd_reg <= '0; lnum_reg <= '0; nmi_reg <= 1'b0;
            fd_reg <= 1'b0; ls_reg <= 1'b0; rd_oam_reg <= 1'b0; rd_buf_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && !paddr)
                mir_reg <= pwdata[2:0];
            if (!in_stall)
                ov_reg <= in_valid;
            if (acc)
            begin
                // retire a load still in flight into the buffer
                if (ld_reg)
                    rbuf_reg <= buf_now;
                ld_reg <= 1'b0;
                rd_reg <= '0; nmi_reg <= 1'b0; fd_reg <= 1'b0; ls_reg <= 1'b0;
                lnum_reg <= '0; rd_oam_reg <= 1'b0; rd_buf_reg <= 1'b0;
                case (op_t'(operation))
                    OP_TICK:
                    begin
                        if (line_reg == LinePre)
                        begin
                            if ((mask_reg[3] || mask_reg[4]) && dot_reg == 9'd1)
                                vbl_reg <= 1'b0;
                        end
                        else if (line_reg < LineVis)
                        begin
                            if (dot_reg == 9'd0)
                            begin
                                ls_reg <= 1'b1;
                                lnum_reg <= line_reg[7:0];
                            end
                        end
                        else if (line_reg == LineVbl && dot_reg == 9'd1)
                        begin
                            vbl_reg <= 1'b1;
                            nmi_reg <= ctrl_reg[7];
                        end
                        if (dot_reg == 9'(DOTS_PER_LINE - 1))
                        begin
                            dot_reg <= '0;
                            if (line_reg + 9'd1 == LineWrap)
                            begin
                                line_reg <= LinePre;
                                fd_reg <= 1'b1;
                            end
                            else
                                line_reg <= line_reg + 9'd1;
                        end
                        else
                            dot_reg <= dot_reg + 9'd1;
                    end
                    OP_READ:
                    begin
                        case (reg_t'(reg_index))
                            REG_STATUS:
                            begin
                                rd_reg <= {vbl_reg, 7'd0};
                                vbl_reg <= 1'b0;
                                tog_reg <= 1'b0;
                            end
                            REG_OAMDAT: rd_oam_reg <= 1'b1;
                            REG_DATA:
                            begin
                                ld_reg <= 1'b1;
                                ld_src_reg <= in_name ? SRC_NAME : (in_pal ? SRC_PAL : SRC_ZERO);
                                if (in_pal)
                                    rd_buf_reg <= 1'b1;
                                else
                                    rd_reg <= buf_now;
                            end
                            default: rd_reg <= '0;
                        endcase
                    end
                    OP_WRITE:
                    begin
                        case (reg_t'(reg_index))
                            REG_CTRL:   ctrl_reg <= write_data;
                            REG_MASK:   mask_reg <= write_data;
                            REG_STATUS: tog_reg <= 1'b0;
                            REG_OAMADR: oam_ptr_reg <= write_data;
                            REG_OAMDAT: oam_ptr_reg <= oam_ptr_reg + 8'd1;
                            REG_SCROLL:
                            begin
                                if (tog_reg) sy_reg <= write_data;
                                else sx_reg <= write_data;
                                tog_reg <= ~tog_reg;
                            end
                            REG_ADDR:
                            begin
                                if (tog_reg) vptr_reg[7:0] <= write_data;
                                else vptr_reg[15:8] <= write_data & 8'hbf;
                                tog_reg <= ~tog_reg;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                if (dat_acc)
                    vptr_reg <= vptr_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
            end
        end
    end

endmodule

FILE: verif/vurt_checker.sv
`timescale 1ns / 100ps

module vurt_checker
    import vurt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        nmi_raise,
    input  logic        frame_done,
    input  logic        line_start,
    input  logic [7:0]  line_number,
    input  logic [7:0]  ctrl_value,
    input  logic [7:0]  mask_value,
    input  logic [7:0]  scroll_x,
    input  logic [7:0]  scroll_y,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] rd;
        logic       nmi;
        logic       fdone;
        logic       lstart;
        logic [7:0] lnum;
        logic [7:0] ctrl;
        logic [7:0] mask;
        logic [7:0] sx;
        logic [7:0] sy;
    } unit_result_t;

    unit_result_t result_q[$];

    logic [2:0]  mirror;
    logic [7:0]  ctrl_r, mask_r, oam_ptr, rbuf, sx_r, sy_r;
    logic        vbl, toggle;
    logic [15:0] vptr;
    logic [8:0]  dot, line;
    logic [7:0]  oam_mem[256];
    logic [7:0]  name_mem[4096];
    logic [7:0]  pal_mem[32];

    function automatic int name_slot(logic [13:0] a);
        logic [1:0] q;
        int         page;
        begin
            q = a[11:10];
            case (mirror)
                3'd1: page = q[0];
                3'd2: page = 0;
                3'd3: page = 1;
                3'd4: page = q;
                default: page = q[1];
            endcase
            return (page * 1024 + a[9:0]) % 4096;
        end
    endfunction

    function automatic int pal_slot(logic [13:0] a);
        return (a[1:0] == 2'd0) ? a[3:0] : a[4:0];
    endfunction

    function automatic logic [7:0] vram_load(logic [13:0] a);
        if (a < 14'h2000) return 8'h00;
        if (a < 14'h3f00) return name_mem[name_slot(a)];
        return pal_mem[pal_slot(a)];
    endfunction

    task automatic vram_store(logic [13:0] a, logic [7:0] v);
        if (a < 14'h2000) return;
        if (a < 14'h3f00) name_mem[name_slot(a)] = v;
        else pal_mem[pal_slot(a)] = v;
    endtask

    task automatic advance_pointer();
        vptr = vptr + (ctrl_r[2] ? 16'd32 : 16'd1);
    endtask

    task automatic predict_request(op_t op, reg_t r, logic [7:0] wd);
        unit_result_t res;
        logic [13:0]  a;
        begin
            res = '0;
            case (op)
                OP_TICK: begin
                    if (line == LinePre) begin
                        if ((mask_r & 8'h18) != 0 && dot == 1) vbl = 1'b0;
                    end else if (line < LineVis) begin
                        if (dot == 0) begin
                            res.lstart = 1'b1;
                            res.lnum   = line[7:0];
                        end
                    end else if (line == LineVbl && dot == 1) begin
                        vbl = 1'b1;
                        res.nmi = ctrl_r[7];
                    end
                    dot = dot + 9'd1;
                    if (dot >= DotsPerLineDef) begin
                        dot  = '0;
                        line = line + 9'd1;
                        if (line == LineWrap) begin
                            line = LinePre;
                            res.fdone = 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    if (r == REG_STATUS) begin
                        res.rd = {vbl, 7'd0};
                        vbl    = 1'b0;
                        toggle = 1'b0;
                    end else if (r == REG_OAMDAT) begin
                        res.rd = oam_mem[oam_ptr];
                    end else if (r == REG_DATA) begin
                        a      = vptr[13:0];
                        res.rd = rbuf;
                        rbuf   = vram_load(a);
                        if (a >= 14'h3f00) res.rd = rbuf;
                        advance_pointer();
                    end
                end
                OP_WRITE: begin
                    case (r)
                        REG_CTRL:   ctrl_r = wd;
                        REG_MASK:   mask_r = wd;
                        REG_STATUS: toggle = 1'b0;
                        REG_OAMADR: oam_ptr = wd;
                        REG_OAMDAT: begin
                            oam_mem[oam_ptr] = wd;
                            oam_ptr = oam_ptr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (toggle) sy_r = wd;
                            else sx_r = wd;
                            toggle = ~toggle;
                        end
                        REG_ADDR: begin
                            if (toggle) vptr[7:0] = wd;
                            else vptr[15:8] = wd & 8'hbf;
                            toggle = ~toggle;
                        end
                        default: begin
                            vram_store(vptr[13:0], wd);
                            advance_pointer();
                        end
                    endcase
                end
                default: ;
            endcase
            res.ctrl = ctrl_r;
            res.mask = mask_r;
            res.sx   = sx_r;
            res.sy   = sy_r;
            result_q.push_back(res);
        end
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // everything driven at posedge, so sample mid-cycle
    always @(negedge clk or negedge rst_n) begin
        unit_result_t e;
        if (!rst_n) begin
            mirror = '0;
            ctrl_r = '0; mask_r = '0; oam_ptr = '0; rbuf = '0;
            sx_r = '0; sy_r = '0; vbl = 1'b1; toggle = 1'b0;
            vptr = '0; dot = '0; line = LinePre;
            result_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 1'b0) mirror = pwdata[2:0];
            if (in_valid && !in_stall)
                predict_request(op_t'(operation), reg_t'(reg_index), write_data);
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected", $time);
                end else begin
                    e = result_q.pop_front();
                    check_field("read_data", e.rd, read_data);
                    check_field("nmi_raise", {7'd0, e.nmi}, {7'd0, nmi_raise});
                    check_field("frame_done", {7'd0, e.fdone}, {7'd0, frame_done});
                    check_field("line_start", {7'd0, e.lstart}, {7'd0, line_start});
                    check_field("line_number", e.lnum, line_number);
                    check_field("ctrl_value", e.ctrl, ctrl_value);
                    check_field("mask_value", e.mask, mask_value);
                    check_field("scroll_x", e.sx, scroll_x);
                    check_field("scroll_y", e.sy, scroll_y);
                end
            end
        end
        pending = result_q.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vurt_pkg::*;

    localparam int CycleLimit = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [2:0]  reg_index = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data, line_number, ctrl_value, mask_value, scroll_x, scroll_y;
    logic        nmi_raise, frame_done, line_start;
    int          fail_count, pending;
    int          send_idle_pct = 22;
    int          recv_idle_pct = 53;
    int          cycles = 0;

    always #5 clk = ~clk;

    video_unit_register_and_timing_core DUT (.*);

    vurt_checker checker_i (.*);

    // receiver backpressure
    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request on the in channel, holding it until taken
    task automatic send(op_t op, reg_t r, logic [7:0] wd);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        reg_index  <= r;
        write_data <= wd;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    task automatic reg_wr(reg_t r, logic [7:0] wd);
        send(OP_WRITE, r, wd);
    endtask

    task automatic reg_rd(reg_t r);
        send(OP_READ, r, 8'($urandom));
    endtask

    task automatic set_pointer(logic [15:0] a);
        reg_rd(REG_STATUS);
        reg_wr(REG_ADDR, a[15:8]);
        reg_wr(REG_ADDR, a[7:0]);
    endtask

    // drain, let the pipe settle, then change the mirroring layout
    task automatic set_mirroring(logic [2:0] m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 1'b0;
        pwdata  <= {29'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mixed register traffic: ticks, reads, writes, no-ops and some address/data sequences
    task automatic register_traffic(int n);
        int k, sel;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                set_pointer({2'b00, $urandom_range(1, 3) == 3 ? 6'h3f : 6'($urandom), 8'($urandom)});
                reg_rd(REG_DATA);
                reg_rd(REG_DATA);
            end else if (sel < 40) begin
                send(OP_TICK, reg_t'($urandom_range(7)), 8'($urandom));
            end else if (sel < 65) begin
                send(OP_READ, reg_t'($urandom_range(7)), 8'($urandom));
            end else if (sel < 95) begin
                send(OP_WRITE, reg_t'($urandom_range(7)), 8'($urandom));
            end else begin
                send(OP_NONE, reg_t'($urandom_range(7)), 8'($urandom));
            end
        end
    endtask

    // runs of ticks with occasional accesses that leave ctrl and mask alone
    task automatic frame_run(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(199) == 0)
                send(($urandom_range(1)) ? OP_READ : OP_WRITE,
                     reg_t'($urandom_range(2, 7)), 8'($urandom));
            else
                send(OP_TICK, REG_CTRL, 8'($urandom));
        end
    endtask

    initial begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the sprite memory and the palette's unmirrored entries
        set_mirroring(3'd4);
        reg_wr(REG_CTRL, 8'h00);
        set_pointer(16'h3f00);
        for (k = 0; k < 32; k++) reg_wr(REG_DATA, 8'($urandom));
        reg_wr(REG_OAMADR, 8'h00);
        for (k = 0; k < 256; k++) reg_wr(REG_OAMDAT, 8'($urandom));

        // directed: reads of every register, write-only reads, extremes
        for (k = 0; k < 8; k++) reg_rd(reg_t'(k));
        reg_wr(REG_STATUS, 8'hff);
        reg_wr(REG_SCROLL, 8'hff);
        reg_wr(REG_STATUS, 8'h00);
        reg_wr(REG_SCROLL, 8'h00);
        reg_wr(REG_SCROLL, 8'hff);
        reg_wr(REG_ADDR, 8'hff);           // high byte keeps bit 6 clear
        reg_wr(REG_ADDR, 8'h00);
        reg_rd(REG_DATA);                  // palette bypass
        set_pointer(16'h1234);
        reg_wr(REG_DATA, 8'haa);           // pattern area is read-only
        reg_rd(REG_DATA);
        reg_wr(REG_CTRL, 8'h84);           // step by 32
        reg_rd(REG_DATA);
        reg_wr(REG_OAMADR, 8'hff);
        reg_wr(REG_OAMDAT, 8'h5a);         // pointer wraps to 0
        reg_rd(REG_OAMDAT);
        send(OP_NONE, REG_DATA, 8'hff);
        reg_wr(REG_MASK, 8'h18);
        send(OP_TICK, REG_CTRL, 8'h00);

        set_mirroring(3'd0);
        register_traffic(105);
        set_mirroring(3'd1);
        register_traffic(105);
        // ticks with nmi enabled and the pre-render clear armed
        reg_wr(REG_CTRL, 8'h80);
        reg_wr(REG_MASK, 8'h18);
        frame_run(40);

        send_idle_pct = 53;
        recv_idle_pct = 22;
        set_mirroring(3'd2);
        register_traffic(105);
        set_mirroring(3'd3);
        register_traffic(105);
        set_mirroring(3'd5);               // out of range falls back to horizontal
        register_traffic(105);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_mirroring(3'd4);
        register_traffic(105);
        set_mirroring(3'd7);
        register_traffic(105);
        reg_wr(REG_CTRL, 8'h00);
        reg_wr(REG_MASK, 8'h00);
        frame_run(40);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/vurt_pkg.sv
rtl/core/video_unit_register_and_timing_core.sv
verif/vurt_checker.sv
verif/tb_top.sv
